>>> hdl/bdpe_pkg.sv
// shared constants, types and codes of the button debounce and press event block
package bdpe_pkg;

	localparam int BUTTONS     = 12;
	localparam int QUEUE_DEPTH = 16;

	localparam int IDX_W       = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
	localparam int Q_W         = $clog2(QUEUE_DEPTH);
	localparam int STAMP_W     = 32;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 1;
	localparam int RAW_W       = 12;
	localparam int BTN_FIELD_W = 4;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd20;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd800;

	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_POLL = 1'b1;

	typedef logic [BUTTONS-1:0] btn_vec_t;
	typedef logic [IDX_W-1:0]   btn_idx_t;
	typedef logic [Q_W-1:0]     q_ptr_t;
	typedef logic [STAMP_W-1:0] stamp_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE   = 1'b0,
		REG_LONG_PRESS = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

	// one queued event: button number and long flag
	typedef struct packed {
		logic                   long_press;
		logic [BTN_FIELD_W-1:0] button;
	} event_t;

	// per-button timestamps held in the stamp ram
	typedef struct packed {
		stamp_t change;
		stamp_t press;
	} stamp_word_t;

	typedef struct packed {
		logic        rd_en;
		btn_idx_t    rd_addr;
		logic        wr_en;
		btn_idx_t    wr_addr;
		stamp_word_t wr_data;
	} stamp_req_t;

	typedef struct packed {
		logic   push;
		event_t new_evt;
		logic   pop;
	} ring_req_t;

	typedef struct packed {
		logic empty;
		logic full;
	} ring_stat_t;

endpackage

>>> hdl/bdpe_channels.sv
// valid/ready channel interfaces for input items and results
interface bdpe_item_if;
	logic                           valid;
	logic                           ready;
	logic                           kind;
	logic [31:0]                    now_ms;
	logic [bdpe_pkg::RAW_W-1:0]     raw_pressed;
	logic [3:0]                     query_button;

	modport source (output valid, kind, now_ms, raw_pressed, query_button, input ready);
	modport sink   (input valid, kind, now_ms, raw_pressed, query_button, output ready);
endinterface

interface bdpe_result_if;
	logic                              valid;
	logic                              ready;
	logic                              event_valid;
	logic [bdpe_pkg::BTN_FIELD_W-1:0]  event_button;
	logic                              event_long;
	logic                              button_held;

	modport source (output valid, event_valid, event_button, event_long, button_held,
		input ready);
	modport sink   (input valid, event_valid, event_button, event_long, button_held,
		output ready);
endinterface

>>> hdl/button_debounce_press_events_unit.sv
// top level: debounce of button levels with short and long press event queue
//
//  channel | dir | handshake     | transaction contents
//  --------+-----+---------------+------------------------------------------------
//  item    | in  | valid/ready   | kind, now_ms, raw_pressed, query_button
//  result  | out | valid/ready   | event_valid, event_button, event_long, button_held
//  cfg     | in  | cfg_we only   | cfg_idx selects debounce or long press time
//
// a tick steps through accept, a walk over every button in turn, then result load
// a poll steps through accept with ring read, then result load
// the walk rate is set by the stamp ram: one read and one write back per cycle
// reset clears levels, flags, stamp valid bits and ring pointers at once
// a result waiting on a stalled output does not block the next item's accept;
// the next result is loaded once the output register frees up
module button_debounce_press_events_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bdpe_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [bdpe_pkg::CFG_W-1:0]      cfg_wdata,
	bdpe_item_if.sink                       item,
	bdpe_result_if.source                   result
);
	import bdpe_pkg::*;

	// configuration registers
	logic [CFG_W-1:0] debounce_q;
	logic [CFG_W-1:0] long_press_q;

	// sequencer
	state_t   state_q;
	state_t   state_nxt;
	btn_idx_t idx_q;
	logic     accept;
	logic     last_btn;
	logic     out_free;
	logic     pop_issue;

	// captured item
	logic       kind_q;
	stamp_t     now_q;
	btn_vec_t   raw_q;
	logic [3:0] query_q;
	logic       pop_q;

	// debounced button masks
	btn_vec_t last_q;
	btn_vec_t stable_q;
	btn_vec_t short_done_q;
	btn_vec_t long_done_q;

	// per-button update
	logic   raw_b;
	logic   chg;
	stamp_t change_n;
	stamp_t press_n;
	stamp_t deb_diff;
	stamp_t long_diff;
	logic   deb_ok;
	logic   tog;
	logic   stable_n;
	logic   short_n;
	logic   long_n;
	logic   push_short;
	logic   long_hit;

	// query result
	btn_vec_t held_vec;
	logic     held;

	// output register
	logic                   out_valid_q;
	logic                   evt_valid_q;
	logic [BTN_FIELD_W-1:0] evt_button_q;
	logic                   evt_long_q;
	logic                   held_q;

	stamp_req_t  stamp_req;
	stamp_word_t stamp_rd;
	ring_req_t   ring_req;
	ring_stat_t  ring_stat;
	event_t      ring_rd;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RST;
			long_press_q <= LONG_PRESS_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_DEBOUNCE:   debounce_q   <= cfg_wdata;
				REG_LONG_PRESS: long_press_q <= cfg_wdata;
			endcase
		end
	end

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign last_btn   = (idx_q == btn_idx_t'(BUTTONS - 1));
	assign out_free   = !out_valid_q || result.ready;
	assign pop_issue  = accept && (item.kind == KIND_POLL) && !ring_stat.empty;

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nxt = (item.kind == KIND_POLL) ? ST_FINISH : ST_WALK;
				end
			end
			ST_WALK: begin
				if (last_btn) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// item capture and button counter
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= item.kind;
			now_q   <= item.now_ms;
			raw_q   <= btn_vec_t'(item.raw_pressed);
			query_q <= item.query_button;
			pop_q   <= pop_issue;
			idx_q   <= '0;
		end else if (state_q == ST_WALK) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// one button per cycle; stamps arrive from the ram read issued a cycle ago
	always_comb begin
		raw_b      = raw_q[idx_q];
		chg        = raw_b ^ last_q[idx_q];
		change_n   = chg ? now_q : stamp_rd.change;
		deb_diff   = now_q - change_n;
		deb_ok     = (deb_diff >= stamp_t'(debounce_q));
		tog        = deb_ok && (raw_b != stable_q[idx_q]);
		stable_n   = tog ? raw_b : stable_q[idx_q];
		press_n    = (tog && raw_b) ? now_q : stamp_rd.press;
		short_n    = short_done_q[idx_q];
		long_n     = long_done_q[idx_q];
		push_short = 1'b0;
		// new press re-arms both events
		if (tog && raw_b) begin
			short_n = 1'b0;
			long_n  = 1'b0;
		end
		// release queues a short event unless a short or long event already went out for this press
		if (tog && !raw_b) begin
			push_short = !short_done_q[idx_q] && !long_done_q[idx_q];
			short_n    = 1'b1;
		end
		long_diff = now_q - press_n;
		long_hit  = stable_n && !long_n && (long_diff >= stamp_t'(long_press_q));
		if (long_hit) begin
			long_n  = 1'b1;
			short_n = 1'b1;
		end
	end

	// mask write back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q       <= '0;
			stable_q     <= '0;
			short_done_q <= '0;
			long_done_q  <= '0;
		end else if (state_q == ST_WALK) begin
			last_q[idx_q]       <= raw_b;
			stable_q[idx_q]     <= stable_n;
			short_done_q[idx_q] <= short_n;
			long_done_q[idx_q]  <= long_n;
		end
	end

	// stamp ram: read next button while writing back the current one
	always_comb begin
		stamp_req.rd_en           = 1'b0;
		stamp_req.rd_addr         = '0;
		if (state_q == ST_IDLE) begin
			stamp_req.rd_en = accept && (item.kind == KIND_TICK);
		end else if (state_q == ST_WALK) begin
			stamp_req.rd_en   = !last_btn;
			stamp_req.rd_addr = idx_q + 1'b1;
		end
		stamp_req.wr_en          = (state_q == ST_WALK);
		stamp_req.wr_addr        = idx_q;
		stamp_req.wr_data.change = change_n;
		stamp_req.wr_data.press  = press_n;
	end

	bdpe_stamp_ram u_stamp_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (stamp_req),
		.rd_data (stamp_rd)
	);

	// at most one event per button per tick, so one push per cycle suffices
	assign ring_req.push               = (state_q == ST_WALK) && (push_short || long_hit);
	assign ring_req.new_evt.long_press = long_hit;
	assign ring_req.new_evt.button     = BTN_FIELD_W'(idx_q);
	assign ring_req.pop                = pop_issue;

	bdpe_event_ring u_event_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (ring_req),
		.stat     (ring_stat),
		.rd_event (ring_rd)
	);

	// held state of the queried button, zero when out of range
	assign held_vec = stable_q >> query_q;
	assign held     = held_vec[0] && (STAMP_W'(query_q) < STAMP_W'(BUTTONS));

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			evt_valid_q  <= pop_q && (kind_q == KIND_POLL);
			evt_button_q <= pop_q ? ring_rd.button : '0;
			evt_long_q   <= pop_q && ring_rd.long_press;
			held_q       <= held;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.event_valid  = evt_valid_q;
	assign result.event_button = evt_button_q;
	assign result.event_long   = evt_long_q;
	assign result.button_held  = held_q;

endmodule

>>> hdl/bdpe_stamp_ram.sv
// per-button change and press timestamps, one read and one write port
module bdpe_stamp_ram (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bdpe_pkg::stamp_req_t  req,
	output bdpe_pkg::stamp_word_t rd_data
);
	import bdpe_pkg::*;

	stamp_word_t mem [BUTTONS];
	btn_vec_t    vld_q;
	stamp_word_t rd_q;
	logic        rd_vld_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_q <= mem[req.rd_addr];
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= vld_q[req.rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

>>> hdl/bdpe_event_ring.sv
// event ring buffer with head and tail pointers
module bdpe_event_ring (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bdpe_pkg::ring_req_t  req,
	output bdpe_pkg::ring_stat_t stat,
	output bdpe_pkg::event_t     rd_event
);
	import bdpe_pkg::*;

	event_t mem [QUEUE_DEPTH];
	q_ptr_t head_q;
	q_ptr_t tail_q;
	q_ptr_t head_nxt;
	q_ptr_t tail_nxt;
	event_t rd_q;

	assign head_nxt   = (head_q == q_ptr_t'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_nxt   = (tail_q == q_ptr_t'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign stat.empty = (head_q == tail_q);
	assign stat.full  = (head_nxt == tail_q);

	always_ff @(posedge clk) begin
		if (req.push && !stat.full) begin
			mem[head_q] <= req.new_evt;
		end
		if (req.pop) begin
			rd_q <= mem[tail_q];
		end
	end

	// a push into a full ring is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (req.push && !stat.full) begin
				head_q <= head_nxt;
			end
			if (req.pop && !stat.empty) begin
				tail_q <= tail_nxt;
			end
		end
	end

	assign rd_event = rd_q;

endmodule

>>> hdl/bdpe_checker.sv
// port-level checks of the button debounce unit, bound to the top level
module bdpe_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             item_valid,
	input logic                             item_ready,
	input logic                             result_valid,
	input logic                             result_ready,
	input logic                             event_valid,
	input logic [bdpe_pkg::BTN_FIELD_W-1:0] event_button,
	input logic                             event_long
);
	import bdpe_pkg::*;

	// a shown result stays until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	// one item in flight: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item accepted while busy");

	// popped events name an existing button
	a_button_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && event_valid |-> (STAMP_W'(event_button) < STAMP_W'(BUTTONS)))
		else $error("event for nonexistent button");

	// no event means zero event fields
	a_no_event_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !event_valid |-> (event_button == '0) && !event_long)
		else $error("event fields set without event");

endmodule

bind button_debounce_press_events_unit bdpe_checker u_bdpe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.event_valid  (result.event_valid),
	.event_button (result.event_button),
	.event_long   (result.event_long)
);
